// File: sv/fat12te_pkg.sv
// Shared types, codes and helpers for the FAT12 table engine.
package fat12te_pkg;

  // Default sizing of the table
  localparam int CLUSTER_COUNT_DEF = 2048;
  localparam int SECTOR_BYTES_DEF  = 512;
  localparam int TABLE_SECTORS_DEF = 8;

  // Backing byte store
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = 12;
  localparam int OFF_W       = 13;

  localparam logic [15:0] ENTRY_MASK = 16'h0FFF;
  localparam logic [15:0] ODD_KEEP   = 16'h000F;
  localparam logic [15:0] EVEN_KEEP  = 16'hF000;
  localparam logic [11:0] ODD_BIT    = 12'h001;

  typedef enum logic [2:0] {
    REQ_GET   = 3'd0,
    REQ_SET   = 3'd1,
    REQ_ALLOC = 3'd2,
    REQ_LOAD  = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NO_FREE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_EVAL,
    S_WR_HI,
    S_RD_WAIT,
    S_DONE
  } state_e;

  // Byte offset of a cluster's entry: c*3/2
  function automatic logic [OFF_W-1:0] entry_off(input logic [11:0] c);
    entry_off = {1'b0, c} + {2'b00, c[11:1]};
  endfunction

  // Pull the 12-bit entry out of its little-endian word
  function automatic logic [11:0] extract_entry(input logic [11:0] c,
                                                input logic [15:0] word);
    logic [15:0] w;
    w = ((c & ODD_BIT) != 12'h000) ? (word >> 4) : word;
    extract_entry = 12'(w & ENTRY_MASK);
  endfunction

endpackage

// File: sv/fat12_table_engine_core.sv
// FAT12 allocation table engine: byte store, entry get/set and free-cluster scan.
//
// Usage:
//  - Requests enter on the s_axis group; tuser carries the request kind
//    (0 get, 1 set, 2 allocate, 3 load byte, 4 read byte, others ignored).
//  - Every request yields exactly one response on the m_axis group with
//    entry_out, byte_out and status (0 ok, 1 cluster out of range,
//    2 no free cluster).
//  - Load the table image with load-byte requests before using entries.
//  - One request is in flight at a time. An allocate scans the clusters in
//    turn, reading the bytes of each entry through the single read port.
//    The next request can be taken in the cycle after the response is
//    loaded into the output register.
//  - The response sits in an output register; a new request is accepted
//    while it waits. A stalled receiver only holds the engine once the
//    following response is ready.
//  - Reset clears the control state only; table contents are undefined
//    until written.
module fat12_table_engine_core #(
  parameter int CLUSTER_COUNT = fat12te_pkg::CLUSTER_COUNT_DEF,
  parameter int SECTOR_BYTES  = fat12te_pkg::SECTOR_BYTES_DEF,
  parameter int TABLE_SECTORS = fat12te_pkg::TABLE_SECTORS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: cluster[11:0], entry_value[23:12], byte_addr[35:24], byte_in[43:36]
  input  logic [47:0] s_axis_tdata_i,
  // tuser: req_type[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: entry_out[11:0], byte_out[19:12], status[21:20]
  output logic [23:0] m_axis_tdata_o
);

  // Table size in bytes, capped at the store
  localparam int TSIZE_RAW = TABLE_SECTORS * SECTOR_BYTES;
  localparam int TSIZE = (TSIZE_RAW > fat12te_pkg::STORE_DEPTH) ?
                         fat12te_pkg::STORE_DEPTH : TSIZE_RAW;
  localparam logic [fat12te_pkg::OFF_W-1:0] TSIZE_W = fat12te_pkg::OFF_W'(TSIZE);
  localparam logic [fat12te_pkg::OFF_W-1:0] CEND_W  =
    fat12te_pkg::OFF_W'(CLUSTER_COUNT + 2);

  // Request fields
  logic [11:0] in_cluster, in_value, in_addr;
  logic [7:0]  in_byte;
  fat12te_pkg::req_e in_req;
  assign in_cluster = s_axis_tdata_i[11:0];
  assign in_value   = s_axis_tdata_i[23:12];
  assign in_addr    = s_axis_tdata_i[35:24];
  assign in_byte    = s_axis_tdata_i[43:36];
  assign in_req     = fat12te_pkg::req_e'(s_axis_tuser_i);

  fat12te_pkg::state_e state_q, state_d;
  fat12te_pkg::req_e   req_q;
  logic [11:0] k_q;        // cluster under work (get/set target or scan pointer)
  logic [11:0] val_q;
  logic [7:0]  lo_q;       // low byte of the entry word
  logic [7:0]  wr_hi_q;    // high byte pending writeback
  logic [11:0] res_entry_q;
  logic [7:0]  res_byte_q;
  fat12te_pkg::status_e res_stat_q;
  logic        out_valid_q;
  logic [23:0] out_data_q;

  // Byte store
  logic [7:0] mem [fat12te_pkg::STORE_DEPTH];
  logic [7:0] rdata_q;
  logic [fat12te_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [7:0] wr_data;
  logic       wr_en;

  logic accept;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Range check on the incoming cluster and on the working cluster
  logic [fat12te_pkg::OFF_W-1:0] in_off, k_off;
  logic in_ok, k_ok;
  assign in_off = fat12te_pkg::entry_off(in_cluster);
  assign k_off  = fat12te_pkg::entry_off(k_q);
  assign in_ok  = (in_cluster >= 12'd2) && ({1'b0, in_cluster} < CEND_W) &&
                  ((in_off + 13'd1) < TSIZE_W);
  assign k_ok   = (k_q >= 12'd2) && ({1'b0, k_q} < CEND_W) &&
                  ((k_off + 13'd1) < TSIZE_W);

  logic [15:0] word, new_word;
  logic [11:0] cur_entry;
  assign word      = {rdata_q, lo_q};
  assign cur_entry = fat12te_pkg::extract_entry(k_q, word);
  always_comb begin
    if ((k_q & fat12te_pkg::ODD_BIT) != 12'h000) begin
      new_word = (word & fat12te_pkg::ODD_KEEP) |
                 ({4'h0, val_q} << 4);
    end else begin
      new_word = (word & fat12te_pkg::EVEN_KEEP) | {4'h0, val_q};
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fat12te_pkg::S_IDLE: begin
        if (accept) begin
          priority case (in_req)
            fat12te_pkg::REQ_GET,
            fat12te_pkg::REQ_SET:   state_d = in_ok ? fat12te_pkg::S_RD_LO
                                                    : fat12te_pkg::S_DONE;
            fat12te_pkg::REQ_ALLOC: state_d = fat12te_pkg::S_RD_LO;
            fat12te_pkg::REQ_READ:  state_d = fat12te_pkg::S_RD_WAIT;
            default:                state_d = fat12te_pkg::S_DONE;
          endcase
        end
      end
      fat12te_pkg::S_RD_LO:   state_d = k_ok ? fat12te_pkg::S_RD_HI : fat12te_pkg::S_DONE;
      fat12te_pkg::S_RD_HI:   state_d = fat12te_pkg::S_EVAL;
      fat12te_pkg::S_EVAL: begin
        priority case (req_q)
          fat12te_pkg::REQ_SET:   state_d = fat12te_pkg::S_WR_HI;
          fat12te_pkg::REQ_ALLOC: state_d = (cur_entry == 12'h000) ?
                                            fat12te_pkg::S_DONE : fat12te_pkg::S_RD_LO;
          default:                state_d = fat12te_pkg::S_DONE;
        endcase
      end
      fat12te_pkg::S_WR_HI:   state_d = fat12te_pkg::S_DONE;
      fat12te_pkg::S_RD_WAIT: state_d = fat12te_pkg::S_DONE;
      fat12te_pkg::S_DONE:    state_d = out_free ? fat12te_pkg::S_IDLE : fat12te_pkg::S_DONE;
      default:                state_d = fat12te_pkg::S_IDLE;
    endcase
  end

  // Memory controls and handshake
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_addr = k_off[fat12te_pkg::ADDR_W-1:0];
    wr_addr = k_off[fat12te_pkg::ADDR_W-1:0];
    wr_data = new_word[7:0];
    wr_en   = 1'b0;
    unique case (state_q)
      fat12te_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        rd_addr = in_addr;
        wr_addr = in_addr;
        wr_data = in_byte;
        wr_en   = accept && (in_req == fat12te_pkg::REQ_LOAD);
      end
      fat12te_pkg::S_RD_LO: rd_addr = k_off[fat12te_pkg::ADDR_W-1:0];
      fat12te_pkg::S_RD_HI: rd_addr = k_off[fat12te_pkg::ADDR_W-1:0] + 12'd1;
      fat12te_pkg::S_EVAL:  wr_en   = (req_q == fat12te_pkg::REQ_SET);
      fat12te_pkg::S_WR_HI: begin
        wr_addr = k_off[fat12te_pkg::ADDR_W-1:0] + 12'd1;
        wr_data = wr_hi_q;
        wr_en   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fat12te_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fat12te_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fat12te_pkg::S_IDLE: begin
        if (accept) begin
          req_q       <= in_req;
          val_q       <= in_value;
          k_q         <= (in_req == fat12te_pkg::REQ_ALLOC) ? 12'd2 : in_cluster;
          res_entry_q <= 12'h000;
          res_byte_q  <= 8'h00;
          res_stat_q  <= ((in_req == fat12te_pkg::REQ_GET ||
                           in_req == fat12te_pkg::REQ_SET) && !in_ok) ?
                         fat12te_pkg::ST_RANGE : fat12te_pkg::ST_OK;
        end
      end
      fat12te_pkg::S_RD_LO: begin
        if (!k_ok) begin
          res_stat_q <= (req_q == fat12te_pkg::REQ_ALLOC) ?
                        fat12te_pkg::ST_NO_FREE : fat12te_pkg::ST_RANGE;
        end
      end
      fat12te_pkg::S_RD_HI: lo_q <= rdata_q;
      fat12te_pkg::S_EVAL: begin
        wr_hi_q <= new_word[15:8];
        if (req_q == fat12te_pkg::REQ_GET) begin
          res_entry_q <= cur_entry;
        end else if (req_q == fat12te_pkg::REQ_ALLOC) begin
          if (cur_entry == 12'h000) begin
            res_entry_q <= k_q;
          end else begin
            k_q <= k_q + 12'd1;
          end
        end
      end
      fat12te_pkg::S_RD_WAIT: res_byte_q <= rdata_q;
      fat12te_pkg::S_DONE: begin
        if (out_free) begin
          out_data_q <= {2'b00, res_stat_q, res_byte_q, res_entry_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Writes to the store only come from a load, the low byte of a set or its high byte
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == fat12te_pkg::S_WR_HI) ||
              (state_q == fat12te_pkg::S_EVAL && req_q == fat12te_pkg::REQ_SET) ||
              (state_q == fat12te_pkg::S_IDLE && accept))
    else $error("unexpected table write");

  // The high entry byte is only fetched for clusters inside the valid range
  a_fetch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fat12te_pkg::S_RD_HI) |-> k_ok)
    else $error("entry fetch for out-of-range cluster");

  // A finished response never overwrites one the receiver has not taken
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fat12te_pkg::S_DONE && out_valid_q && !m_axis_tready_i) |=>
    (state_q == fat12te_pkg::S_DONE))
    else $error("response dropped under stall");

  // Only one request in flight
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("second request accepted while busy");

  // A set always finishes with the high-byte writeback
  a_set_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fat12te_pkg::S_EVAL && req_q == fat12te_pkg::REQ_SET) |=>
    (state_q == fat12te_pkg::S_WR_HI && wr_en))
    else $error("set writeback skipped");

endmodule
